>>> src/lfu_pkg.sv
// Shared types and constants for the LFU cache controller.
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int CAPACITY   = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W     = $clog2(CAPACITY + 1);
    localparam int WORD_W     = 32;
    localparam int CFG_W      = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] read_value;
        logic                     evicted;
        logic signed [WORD_W-1:0] evicted_key;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } status_t;

endpackage

>>> src/lfu_ctrl.sv
// Sequencer that loads a request, scans the entries and applies the update.
`timescale 1ns / 1ps

module lfu_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             out_free,
    input  lfu_pkg::status_t status,
    output lfu_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    cmd.apply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/lfu_dpath.sv
// Entry storage, scan logic for lookup and victim choice, and the update step.
`timescale 1ns / 1ps

module lfu_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lfu_pkg::cmd_t               cmd,
    output lfu_pkg::status_t            status,
    input  lfu_pkg::req_t               req_in,
    input  logic [lfu_pkg::CFG_W-1:0]   cap_in,
    output lfu_pkg::rsp_t               rsp
);

    localparam int N  = lfu_pkg::CAPACITY;
    localparam int IW = lfu_pkg::IDX_W;
    localparam int FW = lfu_pkg::FILL_W;
    localparam int CB = lfu_pkg::COUNT_BITS;
    localparam int WW = lfu_pkg::WORD_W;

    logic [N-1:0]  valid_reg, valid_next;
    logic [WW-1:0] key_reg   [N];
    logic [WW-1:0] data_reg  [N];
    logic [CB-1:0] cnt_reg   [N];
    logic [IW-1:0] rank_reg  [N];
    logic [IW-1:0] rank_next [N];
    logic [FW-1:0] used_reg, used_next;

    lfu_pkg::req_t req_reg;
    logic [IW-1:0] idx_reg;

    logic          found_reg;
    logic [IW-1:0] found_idx_reg;
    logic [CB-1:0] found_cnt_reg;
    logic [IW-1:0] found_rank_reg;
    logic [WW-1:0] found_data_reg;

    logic          free_reg;
    logic [IW-1:0] free_idx_reg;

    logic          best_reg;
    logic [IW-1:0] best_idx_reg;
    logic [CB-1:0] best_cnt_reg;
    logic [IW-1:0] best_rank_reg;
    logic [WW-1:0] best_key_reg;

    logic          cur_valid;
    logic [WW-1:0] cur_key;
    logic [CB-1:0] cur_cnt;
    logic [IW-1:0] cur_rank;
    logic          is_match, is_free, is_better;

    logic [FW-1:0] eff_cap;
    logic          cap_zero, hit_upd, ins, use_free, use_vict, touch;
    logic [IW-1:0] slot;
    logic [IW:0]   thr;
    logic [CB-1:0] cnt_inc;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_key   = key_reg[idx_reg];
    assign cur_cnt   = cnt_reg[idx_reg];
    assign cur_rank  = rank_reg[idx_reg];

    assign is_match  = cur_valid && (cur_key == req_reg.key) && !found_reg;
    assign is_free   = !cur_valid && !free_reg;
    assign is_better = cur_valid && (!best_reg || (cur_cnt < best_cnt_reg) ||
                       ((cur_cnt == best_cnt_reg) && (cur_rank > best_rank_reg)));

    assign status.scan_last = (idx_reg == IW'(N - 1));

    assign eff_cap  = (int'(cap_in) > N) ? FW'(N) : FW'(cap_in);
    assign cap_zero = (eff_cap == '0);
    assign hit_upd  = found_reg && ((req_reg.op == lfu_pkg::OP_GET) || !cap_zero);
    assign ins      = (req_reg.op == lfu_pkg::OP_PUT) && !cap_zero && !found_reg;
    assign use_free = ins && free_reg && (used_reg < eff_cap);
    assign use_vict = ins && !use_free && best_reg;
    assign touch    = hit_upd || use_free || use_vict;
    assign slot     = found_reg ? found_idx_reg : (use_free ? free_idx_reg : best_idx_reg);
    assign thr      = found_reg ? {1'b0, found_rank_reg} :
                      (use_free ? (IW + 1)'(N) : {1'b0, best_rank_reg});
    assign cnt_inc  = (found_cnt_reg == '1) ? found_cnt_reg : found_cnt_reg + 1'b1;

    assign rsp.hit         = found_reg;
    assign rsp.read_value  = ((req_reg.op == lfu_pkg::OP_GET) && found_reg) ?
                             found_data_reg : '1;
    assign rsp.evicted     = use_vict;
    assign rsp.evicted_key = use_vict ? best_key_reg : '0;

    always_comb begin
        valid_next = valid_reg;
        used_next  = used_reg;
        for (int j = 0; j < N; j++) begin
            rank_next[j] = rank_reg[j];
        end
        if (cmd.apply && touch) begin
            for (int j = 0; j < N; j++) begin
                if (IW'(j) == slot) begin
                    rank_next[j] = '0;
                end else if (valid_reg[j] && ({1'b0, rank_reg[j]} < thr)) begin
                    rank_next[j] = rank_reg[j] + 1'b1;
                end
            end
            if (use_free || use_vict) begin
                valid_next[slot] = 1'b1;
            end
            if (use_free) begin
                used_next = used_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
            best_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            if (cmd.load) begin
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                best_reg  <= 1'b0;
                idx_reg   <= '0;
            end else if (cmd.scan) begin
                idx_reg <= status.scan_last ? '0 : idx_reg + 1'b1;
                if (is_match) begin
                    found_reg <= 1'b1;
                end
                if (is_free) begin
                    free_reg <= 1'b1;
                end
                if (is_better) begin
                    best_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_in;
        end
        if (cmd.scan) begin
            if (is_match) begin
                found_idx_reg  <= idx_reg;
                found_cnt_reg  <= cur_cnt;
                found_rank_reg <= cur_rank;
                found_data_reg <= data_reg[idx_reg];
            end
            if (is_free) begin
                free_idx_reg <= idx_reg;
            end
            if (is_better) begin
                best_idx_reg  <= idx_reg;
                best_cnt_reg  <= cur_cnt;
                best_rank_reg <= cur_rank;
                best_key_reg  <= cur_key;
            end
        end
        for (int j = 0; j < N; j++) begin
            rank_reg[j] <= rank_next[j];
        end
        if (cmd.apply) begin
            if (hit_upd) begin
                cnt_reg[slot] <= cnt_inc;
                if (req_reg.op == lfu_pkg::OP_PUT) begin
                    data_reg[slot] <= req_reg.write_value;
                end
            end else if (use_free || use_vict) begin
                key_reg[slot]  <= req_reg.key;
                data_reg[slot] <= req_reg.write_value;
                cnt_reg[slot]  <= CB'(1);
            end
        end
    end

endmodule

>>> src/lfu_cache_controller_unit.sv
// Top level of the LFU cache controller: capacity register, output register and core.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_data  (req_t: op, key, write_value)
// m_        out  m_valid/m_ready    m_data  (rsp_t: hit, read_value, evicted, evicted_key)
// cfg_      in   cfg_wr_en          cfg_wr_data (cap_in_use)
//
// Each request is loaded, then checked in a scan through every entry of the entry
// store, and then the update is applied and the result loaded into the output register.
// Reset clears the valid bits and the fill count at once, so no clearing pass is needed.
// The next request is accepted while a result waits in the output register; the
// update step stalls only when that register is still full and m_ready is low.
`timescale 1ns / 1ps

module lfu_cache_controller_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lfu_pkg::req_t             s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lfu_pkg::rsp_t             m_data,
    input  logic                      cfg_wr_en,
    input  logic [lfu_pkg::CFG_W-1:0] cfg_wr_data
);

    logic [lfu_pkg::CFG_W-1:0] cap_reg;
    logic                      m_valid_reg;
    lfu_pkg::rsp_t             m_data_reg;
    lfu_pkg::cmd_t             cmd;
    lfu_pkg::status_t          status;
    lfu_pkg::rsp_t             rsp;
    logic                      out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    lfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    lfu_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .req_in  (s_data),
        .cap_in  (cap_reg),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= lfu_pkg::CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.apply) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            m_data_reg <= rsp;
        end
    end

endmodule
